### sv/cbfm_pkg.sv
// Package for the clock buffer frame manager: sizes, command and status codes,
// and the controller/datapath command and status structs. No dependencies.
`default_nettype none
package cbfm_pkg;
    localparam int FRAMES      = 16;
    localparam int PIN_BITS    = 8;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(FRAMES);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

    localparam logic [2:0] CMD_READ    = 3'd0;
    localparam logic [2:0] CMD_ALLOC   = 3'd1;
    localparam logic [2:0] CMD_UNPIN   = 3'd2;
    localparam logic [2:0] CMD_FLUSH   = 3'd3;
    localparam logic [2:0] CMD_DISPOSE = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_NOT_PINNED = 3'd2;
    localparam logic [2:0] ST_PINNED     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame;
        logic        hit;
        logic        write_back;
        logic [7:0]  old_file_id;
        logic [31:0] old_page_no;
        logic        last;
    } t_result;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,  // latch request, start scan at frame 0
        OP_SCAN   = 4'd2,  // examine frame at scan index, advance
        OP_HITPIN = 4'd3,
        OP_UNPIN  = 4'd4,
        OP_CLEAR  = 4'd5,  // clear matched frame
        OP_ADV    = 4'd6,  // advance clock hand
        OP_SWEEP  = 4'd7,  // examine hand frame: if not a victim, clear ref bit and advance
        OP_INSTAL = 4'd8,  // install tag at hand
        OP_FCLEAR = 4'd9   // clear frame at scan index if of file and unpinned, advance
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic             match;      // frame at scan index holds request tag
        logic             fmatch;     // frame at scan index valid and of file
        logic             scan_pin;   // frame at scan index pinned
        logic             scan_dirty;
        logic             scan_end;   // scan index is last frame
        logic             found;      // a match was recorded
        logic             any_free;   // some frame at scan has pin zero (tracked)
        logic             hand_take;  // hand frame is a victim
        logic [IDX_W-1:0] scan_idx;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] hand;
        logic [PIN_BITS-1:0] hit_pin;
        logic             hand_wb;
        logic [7:0]       hand_file;
        logic [31:0]      hand_page;
        logic [7:0]       req_file;
        logic [31:0]      scan_page;
        logic             req_dirty;
    } t_dp_stat;
endpackage
`default_nettype wire

### sv/cbfm_if.sv
// Valid/ready channel interfaces for request and result transfers.
// No dependencies.
`default_nettype none
interface cbfm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  file_id;
    logic [31:0] page_no;
    logic        mark_dirty;
    modport source (output valid, command, file_id, page_no, mark_dirty, input ready);
    modport sink   (input valid, command, file_id, page_no, mark_dirty, output ready);
endinterface

interface cbfm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  frame;
    logic        hit;
    logic        write_back;
    logic [7:0]  old_file_id;
    logic [31:0] old_page_no;
    logic        last;
    modport source (output valid, status, frame, hit, write_back, old_file_id,
                    old_page_no, last, input ready);
    modport sink   (input valid, status, frame, hit, write_back, old_file_id,
                    old_page_no, last, output ready);
endinterface
`default_nettype wire

### sv/cbfm_datapath.sv
// Frame table datapath: tags, flags, pin counts, clock hand, scan index.
// Depends on cbfm_pkg; driven by cbfm_ctrl.
`default_nettype none
module cbfm_datapath (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire [7:0]        i_file_id,
    input  wire [31:0]       i_page_no,
    input  wire              i_mark_dirty,
    input  cbfm_pkg::t_dp_cmd i_cmd,
    output cbfm_pkg::t_dp_stat o_stat
);
    import cbfm_pkg::*;

    logic [7:0]          r_tag_file [FRAMES];
    logic [31:0]         r_tag_page [FRAMES];
    logic [FRAMES-1:0]   r_valid, r_dirty, r_ref;
    logic [PIN_BITS-1:0] r_pin [FRAMES];
    logic [IDX_W-1:0]    r_hand, r_scan, r_hit;
    logic                r_found, r_free;
    logic [7:0]          r_file;
    logic [31:0]         r_page;
    logic                r_md;

    logic [IDX_W-1:0] hand_next, scan_next;
    logic s_match, s_fmatch, h_take;

    assign hand_next = (r_hand == LAST_IDX) ? '0 : r_hand + 1'b1;
    assign scan_next = r_scan + 1'b1;
    assign s_fmatch  = r_valid[r_scan] && r_tag_file[r_scan] == r_file;
    assign s_match   = s_fmatch && r_tag_page[r_scan] == r_page;
    assign h_take    = !r_valid[r_hand] || (!r_ref[r_hand] && r_pin[r_hand] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_ref   <= '0;
            r_hand  <= LAST_IDX;
            r_scan  <= '0;
            r_hit   <= '0;
            r_found <= 1'b0;
            r_free  <= 1'b0;
            for (int k = 0; k < FRAMES; k++) r_pin[k] <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_file  <= i_file_id;
                    r_page  <= i_page_no;
                    r_md    <= i_mark_dirty;
                    r_scan  <= '0;
                    r_found <= 1'b0;
                    r_free  <= 1'b0;
                end
                OP_SCAN: begin
                    if (s_match && !r_found) begin
                        r_found <= 1'b1;
                        r_hit   <= r_scan;
                    end
                    if (r_pin[r_scan] == '0) r_free <= 1'b1;
                    r_scan <= scan_next;
                end
                OP_HITPIN: begin
                    r_ref[r_hit] <= 1'b1;
                    if (r_pin[r_hit] != PIN_MAX) r_pin[r_hit] <= r_pin[r_hit] + 1'b1;
                end
                OP_UNPIN: begin
                    if (r_md) r_dirty[r_hit] <= 1'b1;
                    r_pin[r_hit] <= r_pin[r_hit] - 1'b1;
                end
                OP_CLEAR: begin
                    r_valid[r_hit] <= 1'b0;
                    r_dirty[r_hit] <= 1'b0;
                    r_ref[r_hit]   <= 1'b0;
                    r_pin[r_hit]   <= '0;
                end
                OP_ADV: r_hand <= hand_next;
                OP_SWEEP: begin
                    if (!h_take) begin
                        r_ref[r_hand] <= 1'b0;
                        r_hand <= hand_next;
                    end
                end
                OP_INSTAL: begin
                    r_tag_file[r_hand] <= r_file;
                    r_tag_page[r_hand] <= r_page;
                    r_valid[r_hand] <= 1'b1;
                    r_dirty[r_hand] <= 1'b0;
                    r_ref[r_hand]   <= 1'b1;
                    r_pin[r_hand]   <= PIN_BITS'(1);
                end
                OP_FCLEAR: begin
                    if (s_fmatch && r_pin[r_scan] == '0) begin
                        r_valid[r_scan] <= 1'b0;
                        r_dirty[r_scan] <= 1'b0;
                        r_ref[r_scan]   <= 1'b0;
                    end
                    r_scan <= scan_next;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.match      = s_match;
        o_stat.fmatch     = s_fmatch;
        o_stat.scan_pin   = r_pin[r_scan] != '0;
        o_stat.scan_dirty = r_dirty[r_scan];
        o_stat.scan_end   = r_scan == LAST_IDX;
        o_stat.found      = r_found;
        o_stat.any_free   = r_free;
        o_stat.hand_take  = h_take;
        o_stat.scan_idx   = r_scan;
        o_stat.hit_idx    = r_hit;
        o_stat.hand       = r_hand;
        o_stat.hit_pin    = r_pin[r_hit];
        o_stat.hand_wb    = r_valid[r_hand] && r_dirty[r_hand];
        o_stat.hand_file  = r_tag_file[r_hand];
        o_stat.hand_page  = r_tag_page[r_hand];
        o_stat.req_file   = r_file;
        o_stat.scan_page  = r_tag_page[r_scan];
        o_stat.req_dirty  = r_md;
    end

    a_inst_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_INSTAL |-> !r_valid[r_hand] || r_pin[r_hand] == '0)
        else $error("installing over a pinned frame");
    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hand <= LAST_IDX) else $error("clock hand out of range");
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_ADV |=> r_hand != $past(r_hand))
        else $error("hand did not advance");
endmodule
`default_nettype wire

### sv/cbfm_ctrl.sv
// Command sequencer: tag scan, clock sweep, flush walk, result register.
// Depends on cbfm_pkg, cbfm_if; drives cbfm_datapath.
`default_nettype none
module cbfm_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    cbfm_req_if.sink          req,
    cbfm_rsp_if.source        rsp,
    output cbfm_pkg::t_dp_cmd o_cmd,
    input  cbfm_pkg::t_dp_stat i_stat
);
    import cbfm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b00_0001,
        S_SCAN   = 6'b00_0010,
        S_DECIDE = 6'b00_0100,
        S_SWEEP  = 6'b00_1000,
        S_FLUSH  = 6'b01_0000,
        S_OUT    = 6'b10_0000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_op, n_op;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_vld, n_vld;
    t_result r_res, n_res;
    logic r_stg, n_stg;

    function automatic t_result mk(logic [2:0] s, logic [IDX_W-1:0] f, logic h);
        t_result r;
        r = '0;
        r.status = s;
        r.frame  = 4'(f);
        r.hit    = h;
        r.last   = 1'b1;
        return r;
    endfunction

    assign req.ready = r_state == S_IDLE && !r_vld;
    assign rsp.valid = r_vld;
    assign rsp.status = r_res.status;
    assign rsp.frame = r_res.frame;
    assign rsp.hit = r_res.hit;
    assign rsp.write_back = r_res.write_back;
    assign rsp.old_file_id = r_res.old_file_id;
    assign rsp.old_page_no = r_res.old_page_no;
    assign rsp.last = r_res.last;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_vld   = r_vld && !rsp.ready;
        n_res   = r_res;
        n_stg   = r_stg;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (req.valid && req.ready && req.command <= CMD_DISPOSE) begin
                    o_cmd.op = OP_LOAD;
                    n_op  = req.command;
                    n_cnt = '0;
                    n_stg = 1'b0;
                    n_state = (req.command == CMD_FLUSH) ? S_FLUSH : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_stat.scan_end) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_op == CMD_READ || r_op == CMD_ALLOC) begin
                    if (i_stat.found) begin
                        o_cmd.op = OP_HITPIN;
                        n_res = mk(ST_OK, i_stat.hit_idx, 1'b1);
                        n_state = S_OUT;
                    end else begin
                        o_cmd.op = OP_ADV;
                        if (!i_stat.any_free) begin
                            n_res = mk(ST_FULL, '0, 1'b0);
                            n_state = S_OUT;
                        end else n_state = S_SWEEP;
                    end
                end else if (r_op == CMD_UNPIN) begin
                    if (!i_stat.found) n_res = mk(ST_NOT_FOUND, '0, 1'b0);
                    else if (i_stat.hit_pin == '0)
                        n_res = mk(ST_NOT_PINNED, i_stat.hit_idx, 1'b1);
                    else begin
                        o_cmd.op = OP_UNPIN;
                        n_res = mk(ST_OK, i_stat.hit_idx, 1'b1);
                    end
                    n_state = S_OUT;
                end else begin
                    if (!i_stat.found) n_res = mk(ST_OK, '0, 1'b0);
                    else begin
                        o_cmd.op = OP_CLEAR;
                        n_res = mk(ST_OK, i_stat.hit_idx, 1'b1);
                    end
                    n_state = S_OUT;
                end
            end
            S_SWEEP: begin
                if (i_stat.hand_take) begin
                    o_cmd.op = OP_INSTAL;
                    n_res = mk(ST_OK, i_stat.hand, 1'b0);
                    if (i_stat.hand_wb) begin
                        n_res.write_back  = 1'b1;
                        n_res.old_file_id = i_stat.hand_file;
                        n_res.old_page_no = i_stat.hand_page;
                    end
                    n_state = S_OUT;
                end else o_cmd.op = OP_SWEEP;
            end
            S_OUT: begin
                if (!r_vld) begin
                    n_vld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                // a staged result is sent once the next match or the end is seen
                if (!r_vld) begin
                    if (i_stat.fmatch) begin
                        if (r_stg) begin
                            n_vld = 1'b1;
                            n_stg = 1'b0;
                        end else if (i_stat.scan_pin) begin
                            n_res = mk(ST_PINNED, i_stat.scan_idx, 1'b0);
                            n_vld = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.op = OP_FCLEAR;
                            n_res = mk(ST_OK, i_stat.scan_idx, 1'b0);
                            n_res.last = i_stat.scan_end ||
                                         r_cnt == CNT_W'(MAX_RESULTS - 1);
                            if (i_stat.scan_dirty) begin
                                n_res.write_back  = 1'b1;
                                n_res.old_file_id = i_stat.req_file;
                                n_res.old_page_no = i_stat.scan_page;
                            end
                            n_cnt = r_cnt + 1'b1;
                            if (n_res.last) begin
                                n_vld = 1'b1;
                                n_state = S_IDLE;
                            end else n_stg = 1'b1;
                        end
                    end else begin
                        o_cmd.op = OP_FCLEAR;
                        if (i_stat.scan_end) begin
                            if (!r_stg) n_res = mk(ST_OK, '0, 1'b0);
                            n_res.last = 1'b1;
                            n_vld = 1'b1;
                            n_stg = 1'b0;
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
            r_cnt   <= '0;
            r_stg   <= 1'b0;
            r_op    <= CMD_READ;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_cnt   <= n_cnt;
            r_stg   <= n_stg;
            r_op    <= n_op;
        end
        r_res <= n_res;
    end

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS)) else $error("flush count overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !rsp.ready |=> $stable(r_res))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

### sv/clock_buffer_frame_manager_core.sv
// Clock buffer frame manager: frame table of a buffer pool, clock replacement.
// One request channel (command, file_id, page_no, mark_dirty) and one result
// channel (status, frame, hit, write_back, old_file_id, old_page_no, last),
// both valid/ready; a transfer happens when valid and ready are both high.
// Requests are handled one at a time. Read, alloc, unpin and dispose scan the
// tag table one frame a cycle, then pass through a decide state and an output
// state, after which the result is valid. A read or alloc miss adds the clock
// sweep, unless no scanned frame is unpinned, which gives a full status. The
// next request is taken the cycle after the result transfers.
// Flush walks the frames one a cycle and emits up to 16 results, the final one
// flagged last; each result is held until the next matching frame or the end
// of the walk is found, and the walk pauses while a result waits for transfer.
// A stalled receiver holds the result and the block takes no new request.
// Unknown commands are taken and give no result.
// Synchronous reset clears valid, dirty, reference and pin state and puts the
// clock hand at the last frame; tags are undefined until written.
// Depends on cbfm_pkg, cbfm_if, cbfm_datapath, cbfm_ctrl.
`default_nettype none
module clock_buffer_frame_manager_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cbfm_req_if.sink   req,
    cbfm_rsp_if.source rsp
);
    import cbfm_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    cbfm_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .req    (req),
        .rsp    (rsp),
        .o_cmd  (dp_cmd),
        .i_stat (dp_stat)
    );

    cbfm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_file_id   (req.file_id),
        .i_page_no   (req.page_no),
        .i_mark_dirty(req.mark_dirty),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );
endmodule
`default_nettype wire
